### rtl/three_way_sorted_merge_assert.svh
// Assertion macros for the three-way sorted merge.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef THREE_WAY_SORTED_MERGE_ASSERT_SVH
`define THREE_WAY_SORTED_MERGE_ASSERT_SVH
`ifndef SYNTHESIS
`define TSM_ASSERT_HOLD(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tsm assertion failed");
`define TSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsm assertion failed");
`else
`define TSM_ASSERT_HOLD(label, cond)
`define TSM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/tsm_pkg.sv
// Shared types and constants of the three-way sorted merge.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none
package tsm_pkg;
  localparam int NUM_LISTS      = 3;
  localparam int DATA_W         = 32;
  localparam int SEL_W          = 2;
  localparam int LIST_DEPTH_DEF = 16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_MERGE = 1'b1;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic finish;
  } tsm_cmd_t;

  typedef struct packed {
    logic done;
  } tsm_status_t;
endpackage
`default_nettype wire

### rtl/three_way_sorted_merge.sv
// Load request: accepted back to back while busy is low.
// Merge request: busy until all N stored elements are merged; each result passes through
// the per-list registered read port and then the result register, one result per cycle.
// Reset (rst_n, synchronous): counts, read positions and overflow flag cleared; store
// contents are left as they are. Results are one-cycle strobes; the receiver cannot stall.
`default_nettype none
module three_way_sorted_merge
  import tsm_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_op,
  input  wire logic [SEL_W-1:0]         in_list_sel,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_merged_value,
  output logic                          out_last,
  output logic                          out_overflow
);
  tsm_cmd_t    cmd;
  tsm_status_t status;

  tsm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_op  (in_op),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  tsm_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_list_sel      (in_list_sel),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_merged_value (out_merged_value),
    .out_last         (out_last),
    .out_overflow     (out_overflow)
  );
endmodule
`default_nettype wire

### rtl/tsm_ctrl.sv
// Controller of the three-way sorted merge: request handshake and merge sequencing.
// Depends on tsm_pkg; drives commands into tsm_datapath.
`default_nettype none
module tsm_ctrl
  import tsm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        in_op,
  output logic             busy,
  output tsm_cmd_t         cmd,
  input  wire tsm_status_t status
);
  typedef enum logic {S_IDLE, S_MERGE} state_t;

  state_t state_r;
  logic   busy_r;
  logic   accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load  = accept && (in_op == OP_LOAD);
        cmd.start = accept && (in_op == OP_MERGE);
      end
      S_MERGE: begin
        cmd.step   = !status.done;
        cmd.finish = status.done;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept && (in_op == OP_MERGE)) begin
            state_r <= S_MERGE;
            busy_r  <= 1'b1;
          end
        end
        S_MERGE: begin
          if (status.done) begin
            state_r <= S_IDLE;
            busy_r  <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/tsm_datapath.sv
// Datapath of the three-way sorted merge: list stores, counts, head compare, result register.
// Depends on tsm_pkg and three_way_sorted_merge_assert.svh; commanded by tsm_ctrl.
`default_nettype none
`include "three_way_sorted_merge_assert.svh"
module tsm_datapath
  import tsm_pkg::*;
#(
  parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire tsm_cmd_t                 cmd,
  output tsm_status_t                   status,
  input  wire logic [SEL_W-1:0]         in_list_sel,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  output logic signed [DATA_W-1:0]      out_merged_value,
  output logic                          out_last,
  output logic                          out_overflow
);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int RW = $clog2(NUM_LISTS * LIST_DEPTH + 1);
  localparam logic [CW-1:0]    DEPTH_C = CW'(LIST_DEPTH);
  localparam logic [SEL_W-1:0] LISTS_C = SEL_W'(NUM_LISTS);

  logic [CW-1:0]              count_r   [NUM_LISTS];
  logic [CW-1:0]              pos_r     [NUM_LISTS];
  logic [CW-1:0]              pos_nxt   [NUM_LISTS];
  logic [AW-1:0]              rd_addr   [NUM_LISTS];
  logic signed [DATA_W-1:0]   head      [NUM_LISTS];
  logic [NUM_LISTS-1:0]       head_ok;
  logic [RW-1:0]              remain_r;
  logic [RW-1:0]              total;
  logic                       dropped_r;
  logic                       sel_ok;
  logic                       sel_room;
  logic [SEL_W-1:0]           best_idx;
  logic                       best_any;
  logic signed [DATA_W-1:0]   best_val;
  logic                       out_valid_r;
  logic signed [DATA_W-1:0]   out_value_r;
  logic                       out_last_r;
  logic                       out_overflow_r;

  assign sel_ok   = in_list_sel < LISTS_C;
  assign sel_room = sel_ok && (count_r[in_list_sel] < DEPTH_C);

  always_comb begin
    total = '0;
    for (int l = 0; l < NUM_LISTS; l++) begin
      total = total + RW'(count_r[l]);
      head_ok[l] = pos_r[l] < count_r[l];
    end
  end

  always_comb begin
    best_idx = '0;
    best_any = 1'b0;
    best_val = head[0];
    for (int l = 0; l < NUM_LISTS; l++) begin
      if (head_ok[l] && (!best_any || (head[l] < best_val))) begin
        best_idx = SEL_W'(l);
        best_any = 1'b1;
        best_val = head[l];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LISTS; l++) begin
      if (cmd.start) begin
        pos_nxt[l] = '0;
      end else if (cmd.step && (best_idx == SEL_W'(l))) begin
        pos_nxt[l] = pos_r[l] + CW'(1);
      end else begin
        pos_nxt[l] = pos_r[l];
      end
      rd_addr[l] = pos_nxt[l][AW-1:0];
    end
  end

  for (genvar g = 0; g < NUM_LISTS; g++) begin : g_list
    logic [DATA_W-1:0] store_r [LIST_DEPTH];
    logic [DATA_W-1:0] head_r;

    always_ff @(posedge clk) begin
      if (cmd.load && sel_room && (in_list_sel == SEL_W'(g))) begin
        store_r[count_r[g][AW-1:0]] <= in_value;
      end
      head_r <= store_r[rd_addr[g]];
    end

    assign head[g] = head_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LISTS; l++) begin
        count_r[l] <= '0;
        pos_r[l]   <= '0;
      end
      remain_r    <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      for (int l = 0; l < NUM_LISTS; l++) begin
        pos_r[l] <= pos_nxt[l];
      end
      out_valid_r <= cmd.step;
      if (cmd.load) begin
        if (sel_room) begin
          count_r[in_list_sel] <= count_r[in_list_sel] + CW'(1);
        end else if (sel_ok) begin
          dropped_r <= 1'b1;
        end
      end
      if (cmd.start) begin
        remain_r <= total;
      end else if (cmd.step) begin
        remain_r <= remain_r - RW'(1);
      end
      if (cmd.finish) begin
        for (int l = 0; l < NUM_LISTS; l++) begin
          count_r[l] <= '0;
          pos_r[l]   <= '0;
        end
        dropped_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_value_r    <= best_val;
      out_last_r     <= (remain_r == RW'(1));
      out_overflow_r <= dropped_r;
    end
  end

  assign status.done      = (remain_r == '0);
  assign out_valid        = out_valid_r;
  assign out_merged_value = out_value_r;
  assign out_last         = out_last_r;
  assign out_overflow     = out_overflow_r;

  `TSM_ASSERT_HOLD(a_step_has_head, !cmd.step || best_any)
  `TSM_ASSERT_HOLD(a_last_ends_run, !(out_valid_r && out_last_r) || (remain_r == '0))
  `TSM_ASSERT_NEXT(a_finish_clears, cmd.finish, (total == '0) && !dropped_r)
  `TSM_ASSERT_HOLD(a_no_load_in_merge, !(cmd.load && (cmd.step || cmd.finish)))
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking bench for three_way_sorted_merge: loads three lists, merges them and compares
// every merged word against an in-bench model of the list buffers and the head selection.
// Depends on tsm_pkg and the three_way_sorted_merge top level only.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tsm_pkg::*;

  localparam int DEPTH        = LIST_DEPTH_DEF;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_GAP      = 20;
  localparam int PHASE_ITEMS  = 40;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     overflow;
  } merge_result_t;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     start       = 1'b0;
  logic                     in_op       = OP_LOAD;
  logic [SEL_W-1:0]         in_list_sel = '0;
  logic signed [DATA_W-1:0] in_value    = '0;
  logic                     busy;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_merged_value;
  logic                     out_last;
  logic                     out_overflow;

  logic signed [DATA_W-1:0] list_words [NUM_LISTS][DEPTH];
  int                       list_fill  [NUM_LISTS] = '{default: 0};
  logic                     drop_seen  = 1'b0;
  merge_result_t            merge_out_q [$];
  merge_result_t            got_word;

  int error_count  = 0;
  int stall_cycles = 0;
  int idle_pct     = 0;
  int items_sent   = 0;

  three_way_sorted_merge #(
    .LIST_DEPTH(DEPTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_list_sel     (in_list_sel),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_merged_value(out_merged_value),
    .out_last        (out_last),
    .out_overflow    (out_overflow)
  );

  always #6 clk = ~clk;

  task automatic track_request(input logic op, input logic [SEL_W-1:0] sel,
                               input logic signed [DATA_W-1:0] val);
    merge_result_t r;
    int            total;
    int            best;
    int            rd [NUM_LISTS];
    if (op == OP_LOAD) begin
      if (sel < NUM_LISTS) begin
        if (list_fill[sel] < DEPTH) begin
          list_words[sel][list_fill[sel]] = val;
          list_fill[sel]++;
        end else begin
          drop_seen = 1'b1;
        end
      end
    end else begin
      total = 0;
      for (int l = 0; l < NUM_LISTS; l++) begin
        rd[l] = 0;
        total += list_fill[l];
      end
      for (int k = 0; k < total; k++) begin
        best = -1;
        // lowest head wins, ties to the lower list
        for (int l = 0; l < NUM_LISTS; l++) begin
          if (rd[l] < list_fill[l]) begin
            if (best < 0 || list_words[l][rd[l]] < list_words[best][rd[best]]) best = l;
          end
        end
        r.value    = list_words[best][rd[best]];
        r.last     = (k == total - 1);
        r.overflow = drop_seen;
        merge_out_q.push_back(r);
        rd[best]++;
      end
      for (int l = 0; l < NUM_LISTS; l++) list_fill[l] = 0;
      drop_seen = 1'b0;
    end
  endtask

  task automatic send_request(input logic op, input logic [SEL_W-1:0] sel,
                              input logic signed [DATA_W-1:0] val);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_op       <= op;
    in_list_sel <= sel;
    in_value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    track_request(op, sel, val);
    if (op == OP_MERGE || sel < NUM_LISTS) items_sent++;
  endtask

  task automatic test_empty_merge();
    logic [31:0] noise;
    noise = $urandom;
    send_request(OP_MERGE, noise[SEL_W-1:0], $signed(~noise));
    // out-of-range list: ignored, no flag
    send_request(OP_LOAD, 2'd3, 32'sh7FFF_FFFF);
    send_request(OP_MERGE, 2'd3, 32'sh8000_0000);
  endtask

  task automatic test_list_extremes();
    send_request(OP_LOAD, 2'd0, 32'sh8000_0000);
    send_request(OP_LOAD, 2'd1, 32'sh8000_0000);
    send_request(OP_LOAD, 2'd2, -32'sd1);
    send_request(OP_LOAD, 2'd0, 32'sh7FFF_FFFF);
    send_request(OP_LOAD, 2'd1, 32'sd0);
    send_request(OP_MERGE, 2'd2, 32'sh5555_AAAA);
  endtask

  task automatic test_list_overflow();
    for (int k = 0; k <= DEPTH; k++) begin
      send_request(OP_LOAD, 2'd1, 32'(k * 32'h0F0F_0F0F) - 32'sh7000_0000);
    end
    send_request(OP_MERGE, 2'd0, 32'sh0);
  endtask

  task automatic run_merge_batch();
    logic signed [DATA_W-1:0] vals [NUM_LISTS][DEPTH + 3];
    int                       len  [NUM_LISTS];
    int                       pos  [NUM_LISTS];
    int                       remaining;
    int                       pick;
    int                       mode;
    int unsigned              step_max;
    longint                   cur;
    logic [31:0]              noise;
    mode      = $urandom_range(0, 9);
    remaining = 0;
    for (int l = 0; l < NUM_LISTS; l++) begin
      len[l] = $urandom_range(0, 5);
      if ($urandom_range(0, 19) == 0) len[l] = $urandom_range(DEPTH - 1, DEPTH + 2);
      pos[l] = 0;
      if (mode < 5) begin
        cur      = longint'($signed($urandom));
        step_max = 2;
      end else begin
        cur      = -64'sd2147483648 + longint'($urandom_range(0, 32'h3FFF_FFFF));
        step_max = 32'h1800_0000;
      end
      for (int k = 0; k < len[l]; k++) begin
        if (mode < 2) begin
          vals[l][k] = $signed($urandom);
        end else begin
          vals[l][k] = cur[DATA_W-1:0];
          cur += longint'($urandom_range(0, step_max));
          if (cur > 64'sd2147483647) cur = 64'sd2147483647;
        end
      end
      remaining += len[l];
    end
    while (remaining > 0) begin
      noise = $urandom;
      if (noise[3:0] == 4'd0) send_request(OP_LOAD, 2'd3, $signed(noise));
      pick = $urandom_range(0, NUM_LISTS - 1);
      while (pos[pick] >= len[pick]) pick = (pick + 1) % NUM_LISTS;
      send_request(OP_LOAD, pick[SEL_W-1:0], vals[pick][pos[pick]]);
      pos[pick]++;
      remaining--;
    end
    noise = $urandom;
    send_request(OP_MERGE, noise[SEL_W-1:0], $signed($urandom));
  endtask

  task automatic test_random_traffic(input int pct);
    int target;
    idle_pct = pct;
    target   = items_sent + PHASE_ITEMS;
    while (items_sent < target) run_merge_batch();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (merge_out_q.size() == 0) begin
        $display("%0t: unexpected result value %0d last %0b overflow %0b", $time,
                 out_merged_value, out_last, out_overflow);
        error_count++;
      end else begin
        got_word = merge_out_q.pop_front();
        if (out_merged_value !== got_word.value) begin
          $display("%0t: merged_value expected %0d actual %0d", $time, got_word.value,
                   out_merged_value);
          error_count++;
        end
        if (out_last !== got_word.last) begin
          $display("%0t: last expected %0b actual %0b", $time, got_word.last, out_last);
          error_count++;
        end
        if (out_overflow !== got_word.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $time, got_word.overflow,
                   out_overflow);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 13;
    test_empty_merge();
    test_list_extremes();
    test_list_overflow();
    test_random_traffic(13);
    test_random_traffic(73);
    test_random_traffic(0);
    start <= 1'b0;
    while (merge_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
